// ===== hdl/srle_pkg.sv =====
// srle_pkg: shared types and constants of the signed token run-length decoder
// used by srle_front, srle_back and signed_token_rle_decoder; no dependencies
`timescale 1ns / 1ps

package srle_pkg;

   // stream size limit, saturating count
   localparam int unsigned SIZE_W = 31;
   localparam logic [SIZE_W-1:0] SIZE_MAX = 31'h7fff_ffff;

   // run length of one descriptor
   localparam int unsigned COUNT_W = 16;

   // configuration port
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_EXPECTED_SIZE = 1'b0;

   // finishing status codes
   localparam logic [1:0] STATUS_MATCH    = 2'd0;
   localparam logic [1:0] STATUS_MISMATCH = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   // classified word passed from front to back
   typedef struct packed {
      logic               emit;    // produces a result word
      logic               data;    // carries a run
      logic [7:0]         run_byte;
      logic [COUNT_W-1:0] count;
      logic               fin;     // stream ends here
      logic               clear;   // clear stream counters afterwards
   } op_type;

   // result word
   typedef struct packed {
      logic               has_data;
      logic [7:0]         out_byte;
      logic [COUNT_W-1:0] repeat_count;
      logic               finished;
      logic [1:0]         status;
      logic [SIZE_W-1:0]  total_size;
   } result_type;

endpackage

// ===== hdl/srle_fifo.sv =====
// srle_fifo: small register-based first-in first-out queue of words
// generic storage used between the decoder stages; no package dependency
`timescale 1ns / 1ps

module srle_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             full,
   output logic             empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en & ~full;
   assign do_rd   = rd_en & ~empty;
   assign rd_data = store_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr & ~do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd & ~do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // word storage, no reset
   always_ff @(posedge clock) begin
      if (do_wr) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== hdl/srle_front.sv =====
// srle_front: token parser, turns run bytes, zero tokens and end marks into classified words
// depends on srle_pkg for op_type and widths
`timescale 1ns / 1ps

module srle_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [7:0]        in_byte,
   input  logic              end_of_input,
   output logic              op_push,
   output srle_pkg::op_type  op
);

   localparam logic [2:0] PH_TOK_LO = 3'd0;
   localparam logic [2:0] PH_TOK_HI = 3'd1;
   localparam logic [2:0] PH_FILL   = 3'd2;
   localparam logic [2:0] PH_LIT    = 3'd3;
   localparam logic [2:0] PH_DRAIN  = 3'd4;

   logic [2:0]                      phase_ff, phase_in;
   logic [7:0]                      token_low_ff, token_low_in;
   logic [14:0]                     literal_left_ff, literal_left_in;
   logic [srle_pkg::COUNT_W-1:0]    fill_count_ff, fill_count_in;
   logic [15:0]                     raw;
   logic [14:0]                     lit_next;

   assign raw      = {in_byte, token_low_ff};
   assign lit_next = literal_left_ff - 1'b1;

   // byte classification and parser state update
   always_comb begin
      phase_in        = phase_ff;
      token_low_in    = token_low_ff;
      literal_left_in = literal_left_ff;
      fill_count_in   = fill_count_ff;
      op              = '0;
      op.fin          = end_of_input;
      op.clear        = end_of_input;
      op.emit         = end_of_input;
      op_push         = 1'b0;

      case (phase_ff)
         PH_TOK_HI: begin
            if (raw == '0) begin
               op.fin   = 1'b1;
               op.emit  = 1'b1;
               phase_in = PH_DRAIN;
            end else if (raw[15]) begin
               fill_count_in = ~raw + 1'b1;
               phase_in      = PH_FILL;
            end else begin
               literal_left_in = raw[14:0];
               phase_in        = PH_LIT;
            end
         end
         PH_FILL: begin
            op.emit       = 1'b1;
            op.data       = 1'b1;
            op.run_byte   = in_byte;
            op.count      = fill_count_ff;
            fill_count_in = '0;
            phase_in      = PH_TOK_LO;
         end
         PH_LIT: begin
            op.emit         = 1'b1;
            op.data         = 1'b1;
            op.run_byte     = in_byte;
            op.count        = srle_pkg::COUNT_W'(1);
            literal_left_in = lit_next;
            if (lit_next == '0) begin
               phase_in = PH_TOK_LO;
            end
         end
         PH_DRAIN: begin
            // discarded bytes, only the end mark matters
            op.fin  = 1'b0;
            op.emit = 1'b0;
         end
         default: begin
            token_low_in = in_byte;
            phase_in     = PH_TOK_HI;
         end
      endcase

      // end of packed stream clears the parser
      if (end_of_input) begin
         phase_in        = PH_TOK_LO;
         token_low_in    = '0;
         literal_left_in = '0;
         fill_count_in   = '0;
      end

      op_push = take & (op.emit | op.clear);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_TOK_LO;
         token_low_ff    <= '0;
         literal_left_ff <= '0;
         fill_count_ff   <= '0;
      end else if (take) begin
         phase_ff        <= phase_in;
         token_low_ff    <= token_low_in;
         literal_left_ff <= literal_left_in;
         fill_count_ff   <= fill_count_in;
      end
   end

endmodule

// ===== hdl/srle_back.sv =====
// srle_back: size accounting, saturation and finishing status per word
// depends on srle_pkg for op_type, result_type and status codes
`timescale 1ns / 1ps

module srle_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          op_valid,
   input  srle_pkg::op_type              op,
   input  logic                          res_full,
   input  logic [srle_pkg::SIZE_W-1:0]   expected_size,
   output logic                          op_pop,
   output logic                          res_push,
   output srle_pkg::result_type          res
);

   logic [srle_pkg::SIZE_W-1:0] total_ff, total_in;
   logic                        ovf_ff, ovf_in;
   logic [srle_pkg::SIZE_W:0]   sum;
   logic [srle_pkg::SIZE_W-1:0] new_total;
   logic                        new_ovf;

   assign op_pop   = op_valid & ~res_full;
   assign res_push = op_pop & op.emit;

   // saturating add of the run length
   always_comb begin
      sum = {1'b0, total_ff};
      if (op.data) begin
         sum = {1'b0, total_ff} + (srle_pkg::SIZE_W + 1)'(op.count);
      end
      new_ovf   = ovf_ff | sum[srle_pkg::SIZE_W];
      new_total = sum[srle_pkg::SIZE_W] ? srle_pkg::SIZE_MAX : sum[srle_pkg::SIZE_W-1:0];
   end

   // result word
   always_comb begin
      res              = '0;
      res.has_data     = op.data;
      res.out_byte     = op.run_byte;
      res.repeat_count = op.count;
      res.finished     = op.fin;
      res.total_size   = new_total;
      if (op.fin) begin
         if (new_ovf) begin
            res.status = srle_pkg::STATUS_OVERFLOW;
         end else if (new_total == expected_size) begin
            res.status = srle_pkg::STATUS_MATCH;
         end else begin
            res.status = srle_pkg::STATUS_MISMATCH;
         end
      end
   end

   // stream counters, cleared at the end of a packed stream
   always_comb begin
      total_in = total_ff;
      ovf_in   = ovf_ff;
      if (op_pop) begin
         total_in = op.clear ? '0 : new_total;
         ovf_in   = op.clear ? 1'b0 : new_ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         total_ff <= total_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

// ===== hdl/signed_token_rle_decoder.sv =====
// signed_token_rle_decoder: one packed byte accepted per cycle while full is low, sustained rate 1 word/cycle
// a result is registered in the front-to-back queue, then in the result queue, before it is at the head
// front parser classifies in the accepting cycle, back size accounting is combinational on the queue head
// input stalls only while the front-to-back queue is full behind a full result queue
// synchronous active-high reset clears parser, counters, queues and expected_size
// depends on srle_pkg, srle_front, srle_back and srle_fifo
`timescale 1ns / 1ps

module signed_token_rle_decoder #(
   parameter int unsigned MID_DEPTH = 4,
   parameter int unsigned OUT_DEPTH = 2
) (
   input  logic                              clock,
   input  logic                              reset,
   // input byte queue side
   input  logic                              push,
   output logic                              full,
   input  logic [7:0]                        req_in_byte,
   input  logic                              req_end_of_input,
   // result queue side
   output logic                              empty,
   input  logic                              pop,
   output logic                              rsp_has_data,
   output logic [7:0]                        rsp_out_byte,
   output logic [srle_pkg::COUNT_W-1:0]      rsp_repeat_count,
   output logic                              rsp_finished,
   output logic [1:0]                        rsp_status,
   output logic [srle_pkg::SIZE_W-1:0]       rsp_total_size,
   // configuration port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [srle_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [srle_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [srle_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   localparam int unsigned OP_W  = $bits(srle_pkg::op_type);
   localparam int unsigned RES_W = $bits(srle_pkg::result_type);

   logic [srle_pkg::SIZE_W-1:0] expected_ff;
   logic                        reg_hit;
   logic                        take;
   logic                        op_push;
   srle_pkg::op_type            op_front;
   logic [OP_W-1:0]             op_head_bits;
   srle_pkg::op_type            op_head;
   logic                        mid_full, mid_empty;
   logic                        op_pop;
   logic                        res_push;
   srle_pkg::result_type        res_back;
   logic [RES_W-1:0]            res_head_bits;
   srle_pkg::result_type        res_head;
   logic                        res_full;

   // configuration register
   assign pready  = 1'b1;
   assign reg_hit = (paddr[srle_pkg::CSR_ADDR_W-1:2] == srle_pkg::REG_EXPECTED_SIZE);
   assign prdata  = reg_hit ? {1'b0, expected_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= '0;
      end else if (psel & penable & pwrite & pready & reg_hit) begin
         expected_ff <= pwdata[srle_pkg::SIZE_W-1:0];
      end
   end

   // front: token parsing
   assign full = mid_full;
   assign take = push & ~mid_full;

   srle_front u_front (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .in_byte      (req_in_byte),
      .end_of_input (req_end_of_input),
      .op_push      (op_push),
      .op           (op_front)
   );

   srle_fifo #(
      .WIDTH (OP_W),
      .DEPTH (MID_DEPTH)
   ) u_mid_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (op_push),
      .wr_data (op_front),
      .rd_en   (op_pop),
      .rd_data (op_head_bits),
      .full    (mid_full),
      .empty   (mid_empty)
   );

   assign op_head = op_head_bits;

   // back: size accounting and status
   srle_back u_back (
      .clock         (clock),
      .reset         (reset),
      .op_valid      (~mid_empty),
      .op            (op_head),
      .res_full      (res_full),
      .expected_size (expected_ff),
      .op_pop        (op_pop),
      .res_push      (res_push),
      .res           (res_back)
   );

   srle_fifo #(
      .WIDTH (RES_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (res_push),
      .wr_data (res_back),
      .rd_en   (pop),
      .rd_data (res_head_bits),
      .full    (res_full),
      .empty   (empty)
   );

   // result word fields
   assign res_head         = res_head_bits;
   assign rsp_has_data     = res_head.has_data;
   assign rsp_out_byte     = res_head.out_byte;
   assign rsp_repeat_count = res_head.repeat_count;
   assign rsp_finished     = res_head.finished;
   assign rsp_status       = res_head.status;
   assign rsp_total_size   = res_head.total_size;

endmodule

// ===== test/signed_token_rle_decoder_tb.sv =====
// signed_token_rle_decoder_tb: self-checking testbench of the signed token run-length decoder
// drives packed bytes, pops run words and checks them against a predictor in a scoreboard class
// depends on srle_pkg and signed_token_rle_decoder
`timescale 1ns / 1ps

module signed_token_rle_decoder_tb;

   localparam int unsigned HOLD_CYCLES   = 400;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned STALL_LIMIT   = 5000;
   localparam int unsigned PHASE_WORDS   = 660;
   localparam logic [srle_pkg::CSR_ADDR_W-1:0] EXPECTED_SIZE_ADDR =
      {srle_pkg::REG_EXPECTED_SIZE, 2'b00};

   typedef enum logic [2:0] {
      AWAIT_LOW, AWAIT_HIGH, IN_FILL, IN_LITERAL, DRAINING
   } parse_phase_type;

   typedef struct {
      logic [7:0] value;
      logic       last;
   } packed_word_type;

   // predictor of the decoder plus the store of run words still owed
   class run_scoreboard;
      parse_phase_type              phase;
      logic [7:0]                   token_low;
      logic [14:0]                  literal_left;
      logic [16:0]                  fill_left;
      logic [31:0]                  byte_total;
      logic                         overflowed;
      logic [srle_pkg::SIZE_W-1:0]  size_target;
      srle_pkg::result_type         owed_runs[$];
      int unsigned                  errors;

      function new();
         size_target = '0;
         errors = 0;
         clear_stream();
      endfunction

      function void clear_stream();
         phase = AWAIT_LOW;
         token_low = '0;
         literal_left = '0;
         fill_left = '0;
         byte_total = '0;
         overflowed = 1'b0;
      endfunction

      function void set_size_target(logic [srle_pkg::SIZE_W-1:0] v);
         size_target = v;
      endfunction

      // saturating size count
      function void add_total(logic [31:0] n);
         logic [31:0] room;
         room = {1'b0, srle_pkg::SIZE_MAX} - byte_total;
         if (n > room) begin
            byte_total = {1'b0, srle_pkg::SIZE_MAX};
            overflowed = 1'b1;
         end else begin
            byte_total = byte_total + n;
         end
      endfunction

      function string run_text(srle_pkg::result_type r);
         return $sformatf("data=%0d byte=%02h count=%0d fin=%0d status=%0d total=%0d",
                          r.has_data, r.out_byte, r.repeat_count, r.finished, r.status,
                          r.total_size);
      endfunction

      function void fail(string msg);
         errors++;
         if (errors <= 10)
            $display("%s", msg);
      endfunction

      // one accepted packed byte
      function void note_word(logic [7:0] b, logic last);
         logic       has_run;
         logic       fin;
         logic [7:0] run_byte;
         logic [15:0] count;
         logic [15:0] raw;
         srle_pkg::result_type r;
         has_run = 1'b0;
         fin = 1'b0;
         run_byte = '0;
         count = '0;
         raw = {b, token_low};
         case (phase)
            AWAIT_HIGH: begin
               if (raw == 16'h0000) begin
                  fin = 1'b1;
                  phase = DRAINING;
               end else if (raw[15]) begin
                  fill_left = 17'h10000 - {1'b0, raw};
                  phase = IN_FILL;
               end else begin
                  literal_left = raw[14:0];
                  phase = IN_LITERAL;
               end
            end
            IN_FILL: begin
               has_run = 1'b1;
               run_byte = b;
               count = fill_left[15:0];
               add_total({15'd0, fill_left});
               fill_left = '0;
               phase = AWAIT_LOW;
            end
            IN_LITERAL: begin
               has_run = 1'b1;
               run_byte = b;
               count = 16'd1;
               add_total(32'd1);
               literal_left = literal_left - 15'd1;
               if (literal_left == 15'd0)
                  phase = AWAIT_LOW;
            end
            DRAINING: begin
               // bytes after a zero token vanish until the end mark
               if (last)
                  clear_stream();
               return;
            end
            default: begin
               token_low = b;
               phase = AWAIT_HIGH;
            end
         endcase
         if (last)
            fin = 1'b1;
         if (!has_run && !fin)
            return;
         r.has_data = has_run;
         r.out_byte = run_byte;
         r.repeat_count = count;
         r.finished = fin;
         if (!fin)
            r.status = srle_pkg::STATUS_MATCH;
         else if (overflowed)
            r.status = srle_pkg::STATUS_OVERFLOW;
         else if (byte_total == {1'b0, size_target})
            r.status = srle_pkg::STATUS_MATCH;
         else
            r.status = srle_pkg::STATUS_MISMATCH;
         r.total_size = byte_total[srle_pkg::SIZE_W-1:0];
         owed_runs.push_back(r);
         if (last)
            clear_stream();
      endfunction

      // one popped result word against the oldest owed run
      function void check_word(srle_pkg::result_type got);
         srle_pkg::result_type want;
         if (owed_runs.size() == 0) begin
            fail($sformatf("unexpected result word: %s", run_text(got)));
            return;
         end
         want = owed_runs.pop_front();
         if (got.has_data !== want.has_data || got.out_byte !== want.out_byte ||
             got.repeat_count !== want.repeat_count || got.finished !== want.finished ||
             got.status !== want.status || got.total_size !== want.total_size)
            fail($sformatf("result mismatch: expected %s, got %s",
                           run_text(want), run_text(got)));
      endfunction

      function int unsigned pending();
         return owed_runs.size();
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              push = 1'b0;
   logic                              full;
   logic [7:0]                        req_in_byte = '0;
   logic                              req_end_of_input = 1'b0;
   logic                              empty;
   logic                              pop = 1'b0;
   logic                              rsp_has_data;
   logic [7:0]                        rsp_out_byte;
   logic [srle_pkg::COUNT_W-1:0]      rsp_repeat_count;
   logic                              rsp_finished;
   logic [1:0]                        rsp_status;
   logic [srle_pkg::SIZE_W-1:0]       rsp_total_size;
   logic                              psel = 1'b0;
   logic                              penable = 1'b0;
   logic                              pwrite = 1'b0;
   logic [srle_pkg::CSR_ADDR_W-1:0]   paddr = '0;
   logic [srle_pkg::CSR_DATA_W-1:0]   pwdata = '0;
   logic [srle_pkg::CSR_DATA_W-1:0]   prdata;
   logic                              pready;

   run_scoreboard        sb = new();
   packed_word_type      stim_q[$];
   int unsigned          send_idle_pct = 0;
   int unsigned          recv_idle_pct = 0;
   bit                   hold_req = 1'b0;
   int unsigned          stall_cycles = 0;
   srle_pkg::result_type seen_run;

   signed_token_rle_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_in_byte      (req_in_byte),
      .req_end_of_input (req_end_of_input),
      .empty            (empty),
      .pop              (pop),
      .rsp_has_data     (rsp_has_data),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_finished     (rsp_finished),
      .rsp_status       (rsp_status),
      .rsp_total_size   (rsp_total_size),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // clock, 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   assign seen_run = {rsp_has_data, rsp_out_byte, rsp_repeat_count, rsp_finished, rsp_status,
                      rsp_total_size};

   // monitor: accepted words on both sides
   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full)
            sb.note_word(req_in_byte, req_end_of_input);
         if (pop && !empty)
            sb.check_word(seen_run);
      end
   end

   // watchdog on cycles with no accepted word
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("signed_token_rle_decoder_tb NOT OK");
            $finish;
         end
      end
   end

   // receiver: random pops, or a long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // stream building
   function void put_word(logic [7:0] v, logic last);
      packed_word_type w;
      w.value = v;
      w.last = last;
      stim_q.push_back(w);
   endfunction

   function void put_token(logic [15:0] t);
      put_word(t[7:0], 1'b0);
      put_word(t[15:8], 1'b0);
   endfunction

   function void end_on_last();
      stim_q[stim_q.size()-1].last = 1'b1;
   endfunction

   function int unsigned fill_length();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 70)
         return $urandom_range(1, 16);
      else if (r < 85)
         return 32768;
      else
         return $urandom_range(1, 32768);
   endfunction

   function void put_fill(int unsigned n);
      logic [16:0] t;
      t = 17'h10000 - 17'(n);
      put_token(t[15:0]);
      put_word(8'($urandom), 1'b0);
   endfunction

   function void put_literals(int unsigned n);
      put_token(16'(n));
      repeat (n) put_word(8'($urandom), 1'b0);
   endfunction

   // end by mark on last byte, zero token, or zero token and discarded bytes
   function void close_stream(bit allow_last);
      int unsigned r;
      r = $urandom_range(99);
      if (allow_last && r < 40) begin
         end_on_last();
      end else if (r < 70) begin
         put_token(16'h0000);
         end_on_last();
      end else begin
         put_token(16'h0000);
         repeat ($urandom_range(1, 3)) put_word(8'($urandom), 1'b0);
         end_on_last();
      end
   endfunction

   // well-formed stream decoding to exactly the target size
   function void build_sized_stream(int unsigned target);
      int unsigned rem;
      int unsigned c;
      rem = target;
      while (rem > 0) begin
         if (rem > 64 || $urandom_range(1) == 1) begin
            c = (rem > 64) ? $urandom_range(1, 32768) : fill_length();
            if (c > rem)
               c = rem;
            put_fill(c);
         end else begin
            c = $urandom_range(1, 4);
            if (c > rem)
               c = rem;
            put_literals(c);
         end
         rem = rem - c;
      end
      close_stream(target != 0);
   endfunction

   // stream of random runs, sometimes cut short
   function void build_random_stream();
      int unsigned r;
      int unsigned n;
      repeat ($urandom_range(1, 5)) begin
         r = $urandom_range(99);
         if (r < 45) begin
            put_literals($urandom_range(1, 6));
         end else if (r < 85) begin
            put_fill(fill_length());
         end else if (r < 92) begin
            // long literal run cut off early
            n = $urandom_range(1, 32767);
            put_token(16'(n));
            repeat ($urandom_range(0, 4)) put_word(8'($urandom), 1'b0);
            end_on_last();
            return;
         end else begin
            // cut inside a token or before its run bytes
            put_word(8'($urandom), 1'b0);
            if ($urandom_range(1) == 1)
               put_word(8'($urandom), 1'b0);
            end_on_last();
            return;
         end
      end
      close_stream(1'b1);
   endfunction

   function void build_noise();
      repeat ($urandom_range(1, 6)) put_word(8'($urandom), $urandom_range(3) == 0);
      end_on_last();
   endfunction

   function void build_phase(int unsigned sized_pct);
      int unsigned r;
      while (stim_q.size() < PHASE_WORDS) begin
         r = $urandom_range(99);
         if (r < 10)
            build_noise();
         else if (r < 10 + sized_pct)
            build_sized_stream(32'(sb.size_target));
         else
            build_random_stream();
      end
   endfunction

   // sender: offers queued words with random gaps
   task send_all();
      packed_word_type w;
      while (stim_q.size() != 0) begin
         w = stim_q.pop_front();
         while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clock);
         end
         push <= 1'b1;
         req_in_byte <= w.value;
         req_end_of_input <= w.last;
         @(posedge clock);
         while (full) @(posedge clock);
      end
      push <= 1'b0;
   endtask

   // wait until every owed run has come and the pipeline is quiet
   task settle();
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write followed by a read back
   task csr_write(logic [31:0] v);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= EXPECTED_SIZE_ADDR;
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.set_size_target(v[srle_pkg::SIZE_W-1:0]);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== {1'b0, sb.size_target})
         sb.fail($sformatf("expected_size read back: expected %0d, got %0d",
                           sb.size_target, prdata));
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes of tokens, zero token, discarded bytes, truncations
      put_token(16'h0000);
      end_on_last();
      put_token(16'h0001);
      put_word(8'hff, 1'b1);
      put_token(16'h8000);
      put_word(8'h00, 1'b0);
      put_token(16'hffff);
      put_word(8'haa, 1'b0);
      put_token(16'h0000);
      put_word(8'h12, 1'b0);
      put_word(8'h34, 1'b1);
      put_word(8'h05, 1'b1);
      put_token(16'h0003);
      end_on_last();
      put_token(16'h8002);
      end_on_last();
      put_token(16'h7fff);
      put_word(8'h5a, 1'b0);
      put_word(8'h00, 1'b1);
      send_all();

      // sender idles less than receiver
      settle();
      csr_write(32'd0);
      send_idle_pct = 35;
      recv_idle_pct = 53;
      build_phase(30);
      send_all();

      // receiver idles less than sender
      settle();
      csr_write(32'($urandom_range(1, 40)));
      send_idle_pct = 53;
      recv_idle_pct = 35;
      build_phase(40);
      send_all();

      // no idling, with one long receiver hold-off
      settle();
      csr_write(32'($urandom_range(32769, 2000000)));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      build_phase(30);
      hold_req = 1'b1;
      send_all();

      settle();
      if (sb.pending() != 0)
         sb.fail($sformatf("%0d result words never arrived", sb.pending()));
      if (sb.errors == 0)
         $display("signed_token_rle_decoder_tb OK");
      else
         $display("signed_token_rle_decoder_tb NOT OK");
      $finish;
   end

endmodule
